// ===== design/ordered_list_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Ordered list engine assertion macros
// Shared property wrappers for the checker of the ordered list engine.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// Checked at every rising clock edge while the block is out of reset.
`define OLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define OLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/ole_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine package
// Command and status codes, stream widths and the cell control word.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int unsigned InW  = 40;
  localparam int unsigned OutW = 80;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_REMOVE     = 3'd4,
    CMD_FIND       = 3'd5,
    CMD_CLEAR      = 3'd6
  } ole_cmd_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_FULL      = 2'd2,
    STS_NOT_FOUND = 2'd3
  } ole_status_e;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic     cap;    // capture the compare result against the search word
    logic     exec;   // apply the command to the stored words
    ole_cmd_e cmd;
    logic     full;
    logic     empty;
  } ole_ctl_t;

endpackage

// ===== design/ordered_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine
// Bounded double-ended list of words with search and remove, built as a row
// of cells.
// ----------------------------------------------------------------------------
// Usage: each word on the slave stream carries a command and a data word and
// produces exactly one response word on the master stream. The commands push
// or pop at either end, remove the first matching entry, find an entry or
// clear the list. The response reports a status, the front and back entries,
// the entry count and the position of the match for find and remove.
// Command flow: a command is accepted in the idle state, runs through the
// cell row in the next cycle and its response is loaded into the output
// register in the response state that follows, once that register is free.
// This order is set by the cell row: the compare result of every cell is
// registered before the first-match chain and the shift are evaluated, and
// the back entry is selected from the updated row in its own cycle.
// The next command is taken while the previous response still waits.
// Reset clears the entry count and the output valid; the stored words are
// left as they are and are never shown before they are written.
// When the receiver stalls, the response is held and a following command
// completes up to the response cycle, where it waits for the output register.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned DATA_W = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // [2:0] command, [34:3] value, [39:35] zero
  input  logic [ole_pkg::InW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [1:0] status, [33:2] front_value, [65:34] back_value,
  // [70:66] entry_count, [74:71] match_position, [79:75] zero
  output logic [ole_pkg::OutW-1:0] m_axis_tdata
);
  import ole_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0]        state_q, state_d;
  ole_cmd_e          cmd_q;
  logic [DATA_W-1:0] val_q;
  logic [CntW-1:0]   count_q, count_d;
  ole_status_e       status_q, status_d;
  logic [IdxW-1:0]   pos_q, pos_d;
  logic              m_valid_q;
  logic [OutW-1:0]   out_q;

  logic              s_accept;
  logic              out_free;
  logic              out_load;
  logic [DATA_W-1:0] in_val;
  logic [DATA_W-1:0] cell_value;
  ole_ctl_t          ctl;

  logic [DATA_W-1:0] cell_data [DEPTH];
  logic              seen      [DEPTH+1];
  logic [DEPTH-1:0]  first;
  logic              found;
  logic [IdxW-1:0]   first_idx;
  logic [DATA_W-1:0] back_w;
  logic [DATA_W-1:0] front_w;
  logic [OutW-1:0]   out_d;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign out_load      = (state_q == ST_RESP) && out_free;

  // Only the low DATA_W bits of the data word take part.
  assign in_val     = DATA_W'(64'(s_axis_tdata[34:3]));
  assign cell_value = s_accept ? in_val : val_q;

  assign ctl.cap   = s_accept;
  assign ctl.exec  = (state_q == ST_EXEC);
  assign ctl.cmd   = cmd_q;
  assign ctl.full  = (count_q == DepthC);
  assign ctl.empty = (count_q == '0);

  // The match chain starts clear at the front of the row.
  assign seen[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] prev_w;
    logic [DATA_W-1:0] next_w;

    // A push to the front feeds the new word into the first cell.
    if (g == 0) begin : g_head
      assign prev_w = val_q;
    end else begin : g_body
      assign prev_w = cell_data[g-1];
    end

    // The last cell has no successor; its own word keeps it defined.
    if (g == DEPTH - 1) begin : g_tail
      assign next_w = cell_data[g];
    end else begin : g_inner
      assign next_w = cell_data[g+1];
    end

    ole_cell #(
      .DEPTH  (DEPTH),
      .DATA_W (DATA_W),
      .IDX    (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .value_i (cell_value),
      .count_i (count_q),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .seen_i  (seen[g]),
      .seen_o  (seen[g+1]),
      .first_o (first[g]),
      .data_o  (cell_data[g])
    );
  end

  assign found = seen[DEPTH];

  // The first match is one-hot, so its index is the OR of the selected indices.
  always_comb begin
    first_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      first_idx = first_idx | (first[i] ? IdxW'(i) : '0);
    end
  end

  // Command execution: status, position and the new entry count.
  always_comb begin
    status_d = status_q;
    pos_d    = pos_q;
    count_d  = count_q;
    if (state_q == ST_EXEC) begin
      status_d = STS_OK;
      pos_d    = '0;
      case (cmd_q)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (ctl.full) begin
            status_d = STS_FULL;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (ctl.empty) begin
            status_d = STS_EMPTY;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (found) begin
            pos_d   = first_idx;
            count_d = count_q - 1'b1;
          end else begin
            status_d = STS_NOT_FOUND;
          end
        end
        CMD_FIND: begin
          if (found) begin
            pos_d = first_idx;
          end else begin
            status_d = STS_NOT_FOUND;
          end
        end
        CMD_CLEAR: count_d = '0;
        default: ;
      endcase
    end
  end

  // Back entry of the updated row, picked by the last occupied place.
  always_comb begin
    back_w = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_w = back_w
             | (cell_data[i] & {DATA_W{CntW'(i) == (count_q - 1'b1)}});
    end
    if (count_q == '0) begin
      back_w = '0;
    end
  end

  assign front_w = (count_q == '0) ? '0 : cell_data[0];

  assign out_d = {5'd0,
                  4'(32'(pos_q)),
                  5'(32'(count_q)),
                  32'(64'(back_w)),
                  32'(64'(front_w)),
                  status_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_accept) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_RESP;
      ST_RESP: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      cmd_q <= ole_cmd_e'(s_axis_tdata[2:0]);
      val_q <= in_val;
    end
    status_q <= status_d;
    pos_q    <= pos_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// ===== design/ole_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine cell
// Holds one list word, compares it and shifts it to or from its neighbors.
// ----------------------------------------------------------------------------
module ole_cell #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned DATA_W = 32,
  parameter int unsigned IDX    = 0,
  localparam int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  ole_pkg::ole_ctl_t ctl_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic [CntW-1:0]   count_i,
  input  logic [DATA_W-1:0] prev_i,
  input  logic [DATA_W-1:0] next_i,
  input  logic              seen_i,
  output logic              seen_o,
  output logic              first_o,
  output logic [DATA_W-1:0] data_o
);
  import ole_pkg::*;

  localparam logic [CntW-1:0] IdxC = CntW'(IDX);

  logic [DATA_W-1:0] data_q;
  logic              hit_q;
  logic              occupied;
  logic              take_prev;
  logic              take_next;
  logic              load;

  assign occupied = IdxC < count_i;

  always_comb begin
    take_prev = 1'b0;
    take_next = 1'b0;
    load      = 1'b0;
    case (ctl_i.cmd)
      CMD_PUSH_FRONT: take_prev = !ctl_i.full;
      CMD_PUSH_BACK:  load      = !ctl_i.full && (count_i == IdxC);
      CMD_POP_FRONT:  take_next = !ctl_i.empty;
      // Every word at or behind the first match moves one place forward.
      CMD_REMOVE:     take_next = seen_i || hit_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap) begin
      hit_q <= occupied && (data_q == value_i);
    end
    if (ctl_i.exec) begin
      if (take_prev) begin
        data_q <= prev_i;
      end else if (take_next) begin
        data_q <= next_i;
      end else if (load) begin
        data_q <= value_i;
      end
    end
  end

  assign seen_o  = seen_i | hit_q;
  assign first_o = hit_q & ~seen_i;
  assign data_o  = data_q;

endmodule

// ===== design/ole_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine checker
// Port-level properties of the response stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "ordered_list_engine_assert.svh"

module ole_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tvalid,
  input logic                     s_axis_tready,
  input logic [ole_pkg::InW-1:0]  s_axis_tdata,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [ole_pkg::OutW-1:0] m_axis_tdata
);
  import ole_pkg::*;

  logic [1:0] rsp_status;
  logic [4:0] rsp_count;
  logic       rsp_ends_zero;
  logic       rsp_empty;
  logic       in_seen;

  assign rsp_status    = m_axis_tdata[1:0];
  assign rsp_count     = m_axis_tdata[70:66];
  assign rsp_ends_zero = (m_axis_tdata[33:2] == '0) && (m_axis_tdata[65:34] == '0);
  // A zero count field only means an empty list while the list cannot hold 32 words.
  assign rsp_empty     = (rsp_status == STS_EMPTY) || ((rsp_count == '0) && (DEPTH < 32));
  assign in_seen       = s_axis_tvalid && s_axis_tready && (s_axis_tdata[39:35] == '0);

  // A stalled response word holds.
  `OLE_ASSERT(a_rsp_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "response changed while stalled")
  // A full status only comes from a list that is at capacity.
  `OLE_ASSERT(a_full_count, m_axis_tvalid && (rsp_status == STS_FULL) |-> (32'(rsp_count) == DEPTH % 32), "full status with list below capacity")
  // An empty list reports both ends as zero.
  `OLE_ASSERT(a_empty_ends, m_axis_tvalid && rsp_empty |-> rsp_ends_zero, "empty list reports nonzero ends")
  // An accepted command is never answered in the very next cycle.
  `OLE_ASSERT(a_min_latency, in_seen && !m_axis_tvalid |=> !m_axis_tvalid, "response arrived too early")
  // Reset removes any pending response.
  `OLE_ASSERT_ALWAYS(a_reset_idle, !rst_ni && $past(!rst_ni) |-> !m_axis_tvalid, "response valid during reset")

endmodule

bind ordered_list_engine ole_checker #(.DEPTH(DEPTH)) u_ole_checker (.*);

// ===== verif/ordered_list_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine testbench
// Sends command words to the list engine and checks every response word
// against a software copy of the list: directed corner rows first, then
// random traffic of every command code with idle cycles on both streams.
// ----------------------------------------------------------------------------
module ordered_list_engine_tb;
  import ole_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CLK_HALF_NS  = 6;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned RANDOM_WORDS = 550;
  localparam int unsigned IDLE_PCT     = 6;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 200_000;

  // Command code 7 is not part of the command set; the block must report the
  // list unchanged with an ok status.
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  typedef struct packed {
    ole_status_e        status;
    logic [DATA_W-1:0]  front;
    logic [DATA_W-1:0]  back;
    logic [4:0]         count;
    logic [3:0]         pos;
  } list_resp_t;

  typedef struct {
    logic [2:0]        cmd;
    logic [DATA_W-1:0] value;
    bit                typed;
    list_resp_t        resp;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [InW-1:0]    s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OutW-1:0]   m_axis_tdata;

  // Software copy of the list, front at index 0.
  logic [DATA_W-1:0] list_words_q[$];
  list_resp_t        expected_replies_q[$];
  dir_row_t          corner_rows[$];

  int unsigned error_count;
  int unsigned words_sent;
  int unsigned replies_checked;
  int unsigned full_seen;
  int unsigned empty_seen;
  int unsigned missing_seen;
  bit          quiet;
  bit          hold_req;
  bit          hold_done;
  int unsigned hold_left;

  ordered_list_engine #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #(CLK_HALF_NS) clk_i = ~clk_i;

  // Applies one command to the software list and returns the reply it earns.
  function automatic list_resp_t apply_list_command(logic [2:0] cmd, logic [DATA_W-1:0] val);
    list_resp_t r;
    int         hit;
    r.status = STS_OK;
    r.pos    = '0;
    hit      = -1;
    for (int i = 0; i < list_words_q.size(); i++) begin
      if (hit < 0 && list_words_q[i] == val) hit = i;
    end
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (list_words_q.size() >= DEPTH) r.status = STS_FULL;
        else list_words_q.push_front(val);
      end
      CMD_PUSH_BACK: begin
        if (list_words_q.size() >= DEPTH) r.status = STS_FULL;
        else list_words_q.insert(list_words_q.size(), val);
      end
      CMD_POP_FRONT: begin
        if (list_words_q.size() == 0) r.status = STS_EMPTY;
        else void'(list_words_q.pop_front());
      end
      CMD_POP_BACK: begin
        if (list_words_q.size() == 0) r.status = STS_EMPTY;
        else list_words_q.delete(list_words_q.size() - 1);
      end
      CMD_REMOVE: begin
        if (hit < 0) begin
          r.status = STS_NOT_FOUND;
        end else begin
          list_words_q.delete(hit);
          r.pos = hit[3:0];
        end
      end
      CMD_FIND: begin
        if (hit < 0) r.status = STS_NOT_FOUND;
        else r.pos = hit[3:0];
      end
      CMD_CLEAR: begin
        list_words_q.delete();
      end
      default: begin
      end
    endcase
    r.front = (list_words_q.size() != 0) ? list_words_q[0] : '0;
    r.back  = (list_words_q.size() != 0) ? list_words_q[list_words_q.size()-1] : '0;
    r.count = 5'(list_words_q.size());
    return r;
  endfunction

  // Draws a command; the fill mix pushes the list towards full, the drain
  // mix towards empty, so both ends are visited many times.
  function automatic logic [2:0] pick_command(bit fill_mix);
    int unsigned r;
    r = $urandom_range(99);
    if (fill_mix) begin
      if (r < 30) return CMD_PUSH_FRONT;
      if (r < 60) return CMD_PUSH_BACK;
      if (r < 67) return CMD_POP_FRONT;
      if (r < 74) return CMD_POP_BACK;
      if (r < 84) return CMD_REMOVE;
      if (r < 96) return CMD_FIND;
    end else begin
      if (r < 15) return CMD_PUSH_FRONT;
      if (r < 30) return CMD_PUSH_BACK;
      if (r < 50) return CMD_POP_FRONT;
      if (r < 70) return CMD_POP_BACK;
      if (r < 83) return CMD_REMOVE;
      if (r < 96) return CMD_FIND;
    end
    if (r < 98) return CMD_CLEAR;
    return CMD_UNUSED;
  endfunction

  // Pushed words come partly from a small pool so that duplicates exist and
  // the first-match rule of find and remove is exercised.
  function automatic logic [DATA_W-1:0] pick_value(logic [2:0] cmd);
    logic [DATA_W-1:0] pool [4];
    pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5A5A_A5A5, 32'h0000_0001};
    if ((cmd == CMD_REMOVE || cmd == CMD_FIND) && list_words_q.size() != 0 &&
        $urandom_range(99) < 75)
      return list_words_q[$urandom_range(list_words_q.size()-1)];
    if ($urandom_range(99) < 40) return pool[$urandom_range(3)];
    return $urandom;
  endfunction

  // Offers one command word and waits for its handshake. The expectation is
  // recorded at the accepting edge: the typed one for rows that carry it,
  // otherwise the predictor's.
  task automatic send_word(logic [2:0] cmd, logic [DATA_W-1:0] val, bit typed,
                           list_resp_t typed_resp);
    list_resp_t r;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InW-DATA_W-3){1'b0}}, val, cmd};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    r = apply_list_command(cmd, val);
    expected_replies_q.insert(expected_replies_q.size(), typed ? typed_resp : r);
    words_sent++;
  endtask

  function automatic void add_row(logic [2:0] cmd, logic [DATA_W-1:0] val, bit typed,
                                  ole_status_e st, logic [DATA_W-1:0] fr,
                                  logic [DATA_W-1:0] bk, logic [4:0] cnt, logic [3:0] pos);
    dir_row_t row;
    row.cmd         = cmd;
    row.value       = val;
    row.typed       = typed;
    row.resp.status = st;
    row.resp.front  = fr;
    row.resp.back   = bk;
    row.resp.count  = cnt;
    row.resp.pos    = pos;
    corner_rows.insert(corner_rows.size(), row);
  endfunction

  function automatic void build_corner_rows();
    // Empty list: pops, lookups and the unused code; then the first two pushes.
    add_row(CMD_POP_FRONT, 32'h0,         1, STS_EMPTY,     '0, '0, 5'd0, 4'd0);
    add_row(CMD_POP_BACK,  32'h0,         1, STS_EMPTY,     '0, '0, 5'd0, 4'd0);
    add_row(CMD_FIND,      32'h0,         1, STS_NOT_FOUND, '0, '0, 5'd0, 4'd0);
    add_row(CMD_REMOVE,    32'hFFFF_FFFF, 1, STS_NOT_FOUND, '0, '0, 5'd0, 4'd0);
    add_row(CMD_UNUSED,    32'h1234_5678, 1, STS_OK,        '0, '0, 5'd0, 4'd0);
    add_row(CMD_PUSH_BACK, 32'hFFFF_FFFF, 1, STS_OK, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            5'd1, 4'd0);
    add_row(CMD_PUSH_FRONT, 32'h0,        1, STS_OK, 32'h0, 32'hFFFF_FFFF, 5'd2, 4'd0);
    // Fill up to full with distinct words, then push at both ends of the full list.
    for (int i = 0; i < DEPTH - 2; i++)
      add_row(CMD_PUSH_BACK, 32'hA5C3_0000 | i, 0, STS_OK, '0, '0, '0, '0);
    add_row(CMD_PUSH_FRONT, 32'h8000_0000, 0, STS_OK, '0, '0, '0, '0);
    add_row(CMD_PUSH_BACK,  32'h7FFF_FFFF, 0, STS_OK, '0, '0, '0, '0);
    // Match in the last slot, a removal closing a gap, and a miss.
    add_row(CMD_FIND,   32'hA5C3_0000 | (DEPTH - 3), 0, STS_OK, '0, '0, '0, '0);
    add_row(CMD_REMOVE, 32'hFFFF_FFFF,               0, STS_OK, '0, '0, '0, '0);
    add_row(CMD_FIND,   32'h1234_5678,               0, STS_OK, '0, '0, '0, '0);
    add_row(CMD_CLEAR,  32'h0,                       1, STS_OK, '0, '0, 5'd0, 4'd0);
  endfunction

  // Response checker: compares every accepted response word field by field
  // with the oldest expectation.
  always @(posedge clk_i) begin
    list_resp_t exp_r;
    list_resp_t got_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_r.status = ole_status_e'(m_axis_tdata[1:0]);
      got_r.front  = m_axis_tdata[33:2];
      got_r.back   = m_axis_tdata[65:34];
      got_r.count  = m_axis_tdata[70:66];
      got_r.pos    = m_axis_tdata[74:71];
      if (expected_replies_q.size() == 0) begin
        $error("response word with no command waiting: %h", m_axis_tdata);
        error_count++;
      end else begin
        exp_r = expected_replies_q.pop_front();
        replies_checked++;
        if (exp_r.status == STS_FULL)      full_seen++;
        if (exp_r.status == STS_EMPTY)     empty_seen++;
        if (exp_r.status == STS_NOT_FOUND) missing_seen++;
        if (got_r.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, got_r.status);
          error_count++;
        end
        if (got_r.front !== exp_r.front) begin
          $error("front_value: expected %h, got %h", exp_r.front, got_r.front);
          error_count++;
        end
        if (got_r.back !== exp_r.back) begin
          $error("back_value: expected %h, got %h", exp_r.back, got_r.back);
          error_count++;
        end
        if (got_r.count !== exp_r.count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.count, got_r.count);
          error_count++;
        end
        if (got_r.pos !== exp_r.pos) begin
          $error("match_position: expected %0d, got %0d", exp_r.pos, got_r.pos);
          error_count++;
        end
      end
    end
  end

  // Receiver: random stalls, none in the quiet window, and one long hold-off
  // on request so that the engine backs up and stops taking command words.
  initial begin
    m_axis_tready = 1'b1;
    hold_left     = 0;
    hold_done     = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("run exceeded %0d cycles", CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [2:0]        cmd;
    logic [DATA_W-1:0] val;
    bit                fill_mix;
    list_resp_t        none;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    error_count   = 0;
    words_sent    = 0;
    replies_checked = 0;
    full_seen     = 0;
    empty_seen    = 0;
    missing_seen  = 0;
    fill_mix      = 1'b0;
    none          = '0;
    build_corner_rows();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_rows[i])
      send_word(corner_rows[i].cmd, corner_rows[i].value, corner_rows[i].typed,
                corner_rows[i].resp);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 60 == 0) fill_mix = ~fill_mix;
      if (n == 150) hold_req = 1'b1;
      quiet = (n >= 300 && n < 420);
      cmd = pick_command(fill_mix);
      val = pick_value(cmd);
      send_word(cmd, val, 1'b0, none);
    end
    s_axis_tvalid <= 1'b0;
    quiet = 1'b0;

    while (expected_replies_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d command words, checked %0d responses.", words_sent, replies_checked);
    $display("Replies seen: %0d full, %0d empty, %0d not found.",
             full_seen, empty_seen, missing_seen);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
